### rtl/core/lcg_jump_ahead_defines.svh
// ----------------------------------------------------------------------------
// LCG jump-ahead assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef LCG_JUMP_AHEAD_DEFINES_SVH
`define LCG_JUMP_AHEAD_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define LJA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LJA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/lja_pkg.sv
// ----------------------------------------------------------------------------
// LCG jump-ahead package
// Widths, register indexes and the request type of the shared mod-mul unit.
// ----------------------------------------------------------------------------
package lja_pkg;

    // Field width of every register, input and result
    localparam int DATA_W = 63;

    // Configuration port index width and register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MULTIPLIER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INCREMENT  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FINAL_DIV  = 2'd3;

    // Default number of step-count bits honored
    localparam int STEP_BITS_DEF = 63;

    // Operation of the shared unit
    typedef enum logic {
        MODE_MUL,   // a * b mod m
        MODE_MOD    // b mod m
    } t_unit_mode;

    // Request from the sequencer to the unit
    typedef struct packed {
        logic       go;         // start one operation
        t_unit_mode mode;
        logic       post_add;   // add c mod m after the product
    } t_unit_req;

endpackage

### rtl/core/lcg_jump_ahead.sv
// ----------------------------------------------------------------------------
// LCG jump-ahead
// Operation: reduce seed, multiplier and increment, then square-and-multiply
//   the affine map over the bits of steps, apply it to the seed and, if
//   final_divisor != 0, reduce by it. Every operation runs through the
//   one bit-serial mod-mul unit at one operand bit per cycle.
// Throughput: one item at a time; o_busy is high from accept until the beat.
// Reset: synchronous, active low; registers return to m=1, a=0, c=0, div=1.
// ----------------------------------------------------------------------------
module lcg_jump_ahead #(
    parameter int STEP_BITS = lja_pkg::STEP_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lja_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lja_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                           i_start,
    input  logic [lja_pkg::DATA_W-1:0]     i_seed,
    input  logic [lja_pkg::DATA_W-1:0]     i_steps,
    output logic                           o_busy,
    output logic                           o_valid,
    output logic [lja_pkg::DATA_W-1:0]     o_value
);

    localparam int W   = lja_pkg::DATA_W;
    localparam int N_W = (STEP_BITS < W) ? STEP_BITS : W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_X,
        S_RED_P,
        S_RED_Q,
        S_LOOP,
        S_MUL_AQ,
        S_MUL_AP,
        S_MUL_Q,
        S_MUL_P,
        S_FIN,
        S_FIN_MOD
    } t_state;

    // Configuration registers
    logic [W-1:0] r_modulus;
    logic [W-1:0] r_multiplier;
    logic [W-1:0] r_increment;
    logic [W-1:0] r_final_div;

    // Sequencer state and working values
    t_state       r_state;
    logic         r_go;
    logic         r_valid;
    logic [W-1:0] r_value;
    logic [N_W-1:0] r_n;
    logic [W-1:0] r_x;
    logic [W-1:0] r_p;
    logic [W-1:0] r_q;
    logic [W-1:0] r_ap;
    logic [W-1:0] r_aq;

    logic [W-1:0]        m_eff;
    lja_pkg::t_unit_req  unit_req;
    logic [W-1:0]        opa;
    logic [W-1:0]        opb;
    logic [W-1:0]        opc;
    logic [W-1:0]        opm;
    logic                unit_done;
    logic [W-1:0]        unit_res;

    // Zero modulus acts as one
    assign m_eff = (r_modulus == '0) ? W'(1) : r_modulus;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= W'(1);
            r_multiplier <= '0;
            r_increment  <= '0;
            r_final_div  <= W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lja_pkg::CFG_MODULUS:    r_modulus    <= i_cfg_data;
                lja_pkg::CFG_MULTIPLIER: r_multiplier <= i_cfg_data;
                lja_pkg::CFG_INCREMENT:  r_increment  <= i_cfg_data;
                lja_pkg::CFG_FINAL_DIV:  r_final_div  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Select operands for the shared unit by state
    always_comb begin
        unit_req.go       = r_go;
        unit_req.mode     = lja_pkg::MODE_MUL;
        unit_req.post_add = 1'b0;
        opa = r_ap;
        opb = r_x;
        opc = r_aq;
        opm = m_eff;
        case (r_state)
            S_RED_X: begin
                unit_req.mode = lja_pkg::MODE_MOD;
                opb = r_x;
            end
            S_RED_P: begin
                unit_req.mode = lja_pkg::MODE_MOD;
                opb = r_multiplier;
            end
            S_RED_Q: begin
                unit_req.mode = lja_pkg::MODE_MOD;
                opb = r_increment;
            end
            S_MUL_AQ: begin
                unit_req.post_add = 1'b1;
                opa = r_ap;
                opb = r_q;
                opc = r_aq;
            end
            S_MUL_AP: begin
                opa = r_ap;
                opb = r_p;
            end
            S_MUL_Q: begin
                unit_req.post_add = 1'b1;
                opa = r_p;
                opb = r_q;
                opc = r_q;
            end
            S_MUL_P: begin
                opa = r_p;
                opb = r_p;
            end
            S_FIN: begin
                unit_req.post_add = 1'b1;
                opa = r_ap;
                opb = r_x;
                opc = r_aq;
            end
            S_FIN_MOD: begin
                unit_req.mode = lja_pkg::MODE_MOD;
                opb = r_x;
                opm = r_final_div;
            end
            default: ;
        endcase
    end

    lja_modmul_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (unit_req),
        .i_opa    (opa),
        .i_opb    (opb),
        .i_opc    (opc),
        .i_mod    (opm),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    // Sequence the square-and-multiply of the affine map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_go    <= 1'b0;
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_seed;
                        r_n     <= i_steps[N_W-1:0];
                        r_ap    <= (m_eff == W'(1)) ? '0 : W'(1);
                        r_aq    <= '0;
                        r_go    <= 1'b1;
                        r_state <= S_RED_X;
                    end
                end
                S_RED_X: begin
                    if (unit_done) begin
                        r_x     <= unit_res;
                        r_go    <= 1'b1;
                        r_state <= S_RED_P;
                    end
                end
                S_RED_P: begin
                    if (unit_done) begin
                        r_p     <= unit_res;
                        r_go    <= 1'b1;
                        r_state <= S_RED_Q;
                    end
                end
                S_RED_Q: begin
                    if (unit_done) begin
                        r_q     <= unit_res;
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    r_go <= 1'b1;
                    if (r_n == '0) begin
                        r_state <= S_FIN;
                    end else if (r_n[0]) begin
                        r_state <= S_MUL_AQ;
                    end else begin
                        r_state <= S_MUL_Q;
                    end
                end
                S_MUL_AQ: begin
                    if (unit_done) begin
                        r_aq    <= unit_res;
                        r_go    <= 1'b1;
                        r_state <= S_MUL_AP;
                    end
                end
                S_MUL_AP: begin
                    if (unit_done) begin
                        r_ap    <= unit_res;
                        r_go    <= 1'b1;
                        r_state <= S_MUL_Q;
                    end
                end
                S_MUL_Q: begin
                    if (unit_done) begin
                        r_q     <= unit_res;
                        r_go    <= 1'b1;
                        r_state <= S_MUL_P;
                    end
                end
                S_MUL_P: begin
                    if (unit_done) begin
                        r_p     <= unit_res;
                        r_n     <= r_n >> 1;
                        r_state <= S_LOOP;
                    end
                end
                S_FIN: begin
                    if (unit_done) begin
                        if (r_final_div == '0) begin
                            r_value <= unit_res;
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_x     <= unit_res;
                            r_go    <= 1'b1;
                            r_state <= S_FIN_MOD;
                        end
                    end
                end
                S_FIN_MOD: begin
                    if (unit_done) begin
                        r_value <= unit_res;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_value = r_value;

endmodule

### rtl/core/lja_modmul_unit.sv
// ----------------------------------------------------------------------------
// LCG jump-ahead shared modular unit
// Bit-serial shift-add unit: one operand bit per cycle, MSB first. Computes
// a*b mod m (optionally plus c mod m) or b mod m for any 63-bit b.
// ----------------------------------------------------------------------------
module lja_modmul_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lja_pkg::t_unit_req         i_req,
    input  logic [lja_pkg::DATA_W-1:0] i_opa,
    input  logic [lja_pkg::DATA_W-1:0] i_opb,
    input  logic [lja_pkg::DATA_W-1:0] i_opc,
    input  logic [lja_pkg::DATA_W-1:0] i_mod,
    output logic                       o_done,
    output logic [lja_pkg::DATA_W-1:0] o_result
);

    localparam int W     = lja_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    typedef enum logic [1:0] {
        U_IDLE,
        U_RUN,
        U_POST
    } t_ustate;

    typedef lja_pkg::t_unit_mode t_unit_mode_l;

    t_ustate            r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [W-1:0]       r_acc;
    logic [W-1:0]       r_b;
    t_unit_mode_l       r_mode;
    logic               r_post;
    logic               r_done;

    logic         post_phase;
    logic         b_bit;
    logic         add_on;
    logic [W:0]   mod_x;
    logic [W:0]   dbl;
    logic [W:0]   t_red;
    logic [W:0]   sum;
    logic [W:0]   s_red;
    logic [W-1:0] addend;
    logic [W-1:0] n_acc;

    // Double (not in post-add; mod shifts in a b bit), reduce, add, reduce
    always_comb begin
        post_phase = (r_state == U_POST);
        b_bit      = r_b[W-1];
        mod_x      = {1'b0, i_mod};
        if (post_phase) begin
            dbl = {1'b0, r_acc};
        end else begin
            dbl = {r_acc, (r_mode == lja_pkg::MODE_MOD) & b_bit};
        end
        t_red  = (dbl >= mod_x) ? dbl - mod_x : dbl;
        add_on = post_phase | ((r_mode == lja_pkg::MODE_MUL) & b_bit);
        addend = post_phase ? i_opc : i_opa;
        sum    = {1'b0, t_red[W-1:0]} + (add_on ? {1'b0, addend} : '0);
        s_red  = (sum >= mod_x) ? sum - mod_x : sum;
        n_acc  = s_red[W-1:0];
    end

    // Sequence the bits of b, then the optional post-add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_req.go) begin
                        r_acc   <= '0;
                        r_b     <= i_opb;
                        r_mode  <= i_req.mode;
                        r_post  <= i_req.post_add;
                        r_cnt   <= '0;
                        r_state <= U_RUN;
                    end
                end
                U_RUN: begin
                    r_acc <= n_acc;
                    r_b   <= {r_b[W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST) begin
                        if (r_post) begin
                            r_state <= U_POST;
                        end else begin
                            r_state <= U_IDLE;
                            r_done  <= 1'b1;
                        end
                    end
                end
                U_POST: begin
                    r_acc   <= n_acc;
                    r_state <= U_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

### rtl/core/lja_checker.sv
// ----------------------------------------------------------------------------
// LCG jump-ahead checker
// Port-level checks of the start/busy/strobe sequencing, bound to the top.
// ----------------------------------------------------------------------------
`include "lcg_jump_ahead_defines.svh"

module lja_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid
);

    // An accepted beat keeps the block busy
    `LJA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "accept idle")

    // The result strobe comes with the block free for the next beat
    `LJA_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy, "result while busy")

    // One strobe per result
    `LJA_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "strobe held")

    // Busy ends only with a result
    `LJA_ASSERT_NOW(a_busy_end, i_clk, i_rst_n, $fell(o_busy), o_valid, "busy end")

endmodule

bind lcg_jump_ahead lja_checker u_lja_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

### tb/sv/lja_jump_checker.sv
// ----------------------------------------------------------------------------
// LCG jump-ahead checker
// Watches the register port, the command channel and the result beats. It
// keeps its own copy of the generator registers and works out the jumped
// state for every accepted command. Each result beat is compared with the
// oldest pending value. The block under test has no other state.
// ----------------------------------------------------------------------------
module lja_jump_checker
    import lja_pkg::*;
#(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_data,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic [DATA_W-1:0]     i_seed,
    input  logic [DATA_W-1:0]     i_steps,
    input  logic                  i_valid,
    input  logic [DATA_W-1:0]     i_value,
    output int                    o_pending,
    output int                    o_errors
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [DATA_W-1:0] word_t;

    // Shadow copy of the generator registers
    word_t modulus_r  = word_t'(1);
    word_t mult_r     = '0;
    word_t incr_r     = '0;
    word_t fdiv_r     = word_t'(1);

    word_t jumped_q[$];
    word_t oldest_value;
    int    err_cnt = 0;

    // (a + b) mod m, operands already reduced
    function automatic word_t add_mod(word_t a, word_t b, word_t m);
        logic [DATA_W:0] sum;
        sum = a + b;
        if (sum >= m) begin
            sum = sum - m;
        end
        return sum[DATA_W-1:0];
    endfunction

    // (a * b) mod m through a full-width product
    function automatic word_t mul_mod(word_t a, word_t b, word_t m);
        logic [2*DATA_W-1:0] prod;
        prod = a * b;
        prod = prod % m;
        return prod[DATA_W-1:0];
    endfunction

    // Generator state after `steps` steps from `seed`, then the output divisor
    function automatic word_t jump_state(word_t seed, word_t steps);
        word_t       m;
        word_t       n;
        word_t       x;
        word_t       p;
        word_t       q;
        word_t       acc_p;
        word_t       acc_q;
        word_t       r;
        logic [63:0] mask;
        m     = (modulus_r == '0) ? word_t'(1) : modulus_r;
        mask  = (STEP_BITS >= 64) ? '1 : ((64'd1 << STEP_BITS) - 64'd1);
        n     = steps & mask[DATA_W-1:0];
        x     = seed % m;
        p     = mult_r % m;
        q     = incr_r % m;
        acc_p = word_t'(1) % m;
        acc_q = '0;
        // Square the affine map, fold it in on each set count bit
        while (n != '0) begin
            if (n[0]) begin
                acc_q = add_mod(mul_mod(acc_p, q, m), acc_q, m);
                acc_p = mul_mod(acc_p, p, m);
            end
            q = add_mod(mul_mod(p, q, m), q, m);
            p = mul_mod(p, p, m);
            n = n >> 1;
        end
        r = add_mod(mul_mod(acc_p, x, m), acc_q, m);
        if (fdiv_r != '0) begin
            r = r % fdiv_r;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            modulus_r = word_t'(1);
            mult_r    = '0;
            incr_r    = '0;
            fdiv_r    = word_t'(1);
            jumped_q.delete();
        end else begin
            // Retire a result beat against the oldest command
            if (i_valid) begin
                if (jumped_q.size() == 0) begin
                    $error("value: result beat with nothing pending, actual %0d", i_value);
                    err_cnt++;
                end else begin
                    oldest_value = jumped_q.pop_front();
                    if (i_value !== oldest_value) begin
                        $error("value mismatch: expected %0d, actual %0d",
                               oldest_value, i_value);
                        err_cnt++;
                    end
                end
            end
            // Predict an accepted command beat
            if (i_start && !i_busy) begin
                jumped_q.push_back(jump_state(i_seed, i_steps));
            end
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MODULUS:    modulus_r = i_cfg_data;
                    CFG_MULTIPLIER: mult_r    = i_cfg_data;
                    CFG_INCREMENT:  incr_r    = i_cfg_data;
                    CFG_FINAL_DIV:  fdiv_r    = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= jumped_q.size();
        o_errors  <= err_cnt;
    end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// LCG jump-ahead testbench top
// Drives register settings and jump commands into the block, first a
// directed set of corner cases, then random phases with random settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

    import lja_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [DATA_W-1:0] word_t;

    localparam word_t WORD_MAX   = '1;
    localparam int    IDLE_LIMIT = 100_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [DATA_W-1:0]     i_cfg_data;
    logic                  i_start;
    logic [DATA_W-1:0]     i_seed;
    logic [DATA_W-1:0]     i_steps;
    logic                  o_busy;
    logic                  o_valid;
    logic [DATA_W-1:0]     o_value;

    int pending_count;
    int fail_count;
    int idle_cycles = 0;
    int gap_max     = 6;

    lcg_jump_ahead uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_start    (i_start),
        .i_seed     (i_seed),
        .i_steps    (i_steps),
        .o_busy     (o_busy),
        .o_valid    (o_valid),
        .o_value    (o_value)
    );

    lja_jump_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_start    (i_start),
        .i_busy     (o_busy),
        .i_seed     (i_seed),
        .i_steps    (i_steps),
        .i_valid    (o_valid),
        .i_value    (o_value),
        .o_pending  (pending_count),
        .o_errors   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic word_t rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[DATA_W-1:0];
    endfunction

    function automatic word_t pick_modulus();
        case ($urandom_range(0, 5))
            0:       return WORD_MAX;
            1:       return '0;
            2:       return word_t'($urandom_range(2, 50));
            3:       return word_t'($urandom);
            default: return rand_word();
        endcase
    endfunction

    function automatic word_t pick_operand();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return WORD_MAX;
            2:       return word_t'($urandom_range(1, 1000));
            3:       return word_t'($urandom);
            default: return rand_word();
        endcase
    endfunction

    function automatic word_t pick_divisor();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return word_t'(1);
            2:       return WORD_MAX;
            3:       return word_t'($urandom_range(2, 100));
            default: return rand_word();
        endcase
    endfunction

    // Mostly short counts, with a rare long one
    function automatic word_t pick_steps();
        int    sel;
        int    len;
        word_t mask;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            return rand_word();
        end
        len  = (sel == 1) ? 20 : $urandom_range(1, 10);
        mask = (word_t'(1) << len) - word_t'(1);
        return rand_word() & mask;
    endfunction

    // Drop start and hold until every result beat is back
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    task automatic put_reg(logic [CFG_ADDR_W-1:0] addr, word_t data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Reprogram all registers while the block is idle
    task automatic set_config(word_t m, word_t a, word_t c, word_t div);
        drain_results();
        put_reg(CFG_MODULUS, m);
        put_reg(CFG_MULTIPLIER, a);
        put_reg(CFG_INCREMENT, c);
        put_reg(CFG_FINAL_DIV, div);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one command beat, hold it until the block takes it
    task automatic send_job(word_t seed, word_t steps);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_seed  <= seed;
        i_steps <= steps;
        do @(posedge i_clk); while (o_busy);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= CFG_MODULUS;
        i_cfg_data <= '0;
        i_start    <= 1'b0;
        i_seed     <= '0;
        i_steps    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at their reset values: every state collapses to zero
        send_job(WORD_MAX, word_t'(1));
        send_job(word_t'(5), '0);

        // Largest modulus, seed equal to it, zero steps, longest counts, no divisor
        set_config(WORD_MAX, WORD_MAX - 1, WORD_MAX - 1, '0);
        send_job(WORD_MAX, '0);
        send_job(WORD_MAX, word_t'(1));
        send_job('0, word_t'(1));
        send_job(word_t'(12345), WORD_MAX);
        send_job(rand_word(), word_t'(1) << (DATA_W - 1));

        // Zero modulus behaves as one
        set_config('0, rand_word(), rand_word(), '0);
        send_job(rand_word(), word_t'(7));
        send_job(WORD_MAX, word_t'(3));

        // Multiplier and increment above a small prime modulus
        set_config(word_t'(1000003), WORD_MAX, WORD_MAX, word_t'(7));
        send_job(WORD_MAX, '0);
        send_job('0, word_t'(3));
        send_job(rand_word(), word_t'(1000));

        // Zero multiplier: one step lands on the increment
        set_config(word_t'(97), '0, word_t'(5), '0);
        send_job(word_t'(40), word_t'(1));
        send_job(word_t'(40), word_t'(10));

        // Counting generator with the largest divisor
        set_config(WORD_MAX, word_t'(1), word_t'(1), WORD_MAX);
        send_job(WORD_MAX - 2, word_t'(1));
        send_job(WORD_MAX - 2, word_t'(2));
        send_job(rand_word(), rand_word());

        // Random phases, one without sender gaps
        for (int phase = 0; phase < 5; phase++) begin
            gap_max = (phase == 2) ? 0 : 6;
            set_config(pick_modulus(), pick_operand(), pick_operand(), pick_divisor());
            for (int n = 0; n < 20; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    drain_results();
                end
                case ($urandom_range(0, 4))
                    0:       send_job('0, pick_steps());
                    1:       send_job(WORD_MAX, pick_steps());
                    2:       send_job(word_t'($urandom_range(0, 1000)), pick_steps());
                    default: send_job(rand_word(), pick_steps());
                endcase
            end
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/lja_pkg.sv
rtl/core/lja_modmul_unit.sv
rtl/core/lcg_jump_ahead.sv
rtl/core/lja_checker.sv
tb/sv/lja_jump_checker.sv
tb/sv/tb_top.sv
